### rtl/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg
// Shared widths, reset values, register indexes and the command and status
// structs that pass between the windowed statistics controller and datapath.
// ----------------------------------------------------------------------------
package wss_pkg;

  localparam int unsigned SAMPLE_BITS     = 12;
  localparam int unsigned COUNT_BITS      = 16;
  localparam int unsigned EFF_BITS        = COUNT_BITS + 1;
  localparam int unsigned MEAN_SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned SQUARE_SUM_BITS = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned MSQ_BITS        = 2 * SAMPLE_BITS;
  localparam int unsigned DIV_STEPS       = SQUARE_SUM_BITS;
  localparam int unsigned SQRT_STEPS      = SAMPLE_BITS;
  localparam int unsigned STEP_BITS       = $clog2(DIV_STEPS);

  localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(36764);
  localparam logic [COUNT_BITS-1:0] MEAN_RESET   = COUNT_BITS'(1838);

  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEAN_COUNT   = 1'b1;

  typedef struct packed {
    logic accept;
    logic close;
    logic div_step;
    logic mean_fix;
    logic sqrt_set;
    logic sqrt_step;
    logic publish;
  } wss_cmd_t;

  typedef struct packed {
    logic close;
  } wss_status_t;

endpackage

### rtl/wss_datapath.sv
// ----------------------------------------------------------------------------
// wss_datapath
// Configuration registers, window accumulators, shared restoring divider,
// bit-pair square root and the output register.
// ----------------------------------------------------------------------------
module wss_datapath
  import wss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COUNT_BITS-1:0]   cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  input  wss_cmd_t                cmd_i,
  output wss_status_t             status_o,
  output logic [SAMPLE_BITS-1:0]  max_value_o,
  output logic [SAMPLE_BITS-1:0]  min_value_o,
  output logic [SAMPLE_BITS-1:0]  peak_to_peak_o,
  output logic [SAMPLE_BITS-1:0]  mean_value_o,
  output logic [SAMPLE_BITS-1:0]  rms_value_o
);

  logic [COUNT_BITS-1:0]      win_cfg_q, mean_cfg_q;
  logic [COUNT_BITS-1:0]      index_q;
  logic [SAMPLE_BITS-1:0]     max_q, min_q;
  logic [MEAN_SUM_BITS-1:0]   mean_sum_q;
  logic [SQUARE_SUM_BITS-1:0] square_sum_q;

  logic [SAMPLE_BITS-1:0]     snap_max_q, snap_min_q;
  logic [SQUARE_SUM_BITS-1:0] snap_sq_q;
  logic [EFF_BITS-1:0]        snap_taken_q;

  logic [SQUARE_SUM_BITS-1:0] quo_q;
  logic [EFF_BITS-1:0]        rem_q, den_q;
  logic [SAMPLE_BITS-1:0]     mean_q;

  logic [MSQ_BITS-1:0]        rad_q;
  logic [SAMPLE_BITS-1:0]     root_q;
  logic [SAMPLE_BITS:0]       srem_q;

  logic [SAMPLE_BITS-1:0]     out_max_q, out_min_q, out_p2p_q, out_mean_q, out_rms_q;

  logic [EFF_BITS-1:0]        win_eff, mc_eff, avg_n, avg_fin, taken;
  logic [SAMPLE_BITS-1:0]     max_nx, min_nx;
  logic [MEAN_SUM_BITS-1:0]   mean_nx;
  logic [MSQ_BITS-1:0]        square;
  logic [SQUARE_SUM_BITS-1:0] sq_nx;
  logic [EFF_BITS:0]          div_shift;
  logic                       div_ge;
  logic [EFF_BITS-1:0]        rem_nx;
  logic [SQUARE_SUM_BITS-1:0] quo_nx;
  logic [SAMPLE_BITS+2:0]     sq_shift, sq_trial;
  logic                       sq_ge;

  always_comb begin
    win_eff = {win_cfg_q == '0, win_cfg_q};
    mc_eff  = {mean_cfg_q == '0, mean_cfg_q};
    avg_n   = (mc_eff > win_eff) ? win_eff : mc_eff;
    taken   = {1'b0, index_q} + EFF_BITS'(1);
    avg_fin = (avg_n > taken) ? taken : avg_n;
    status_o.close = (taken >= win_eff);

    max_nx = (sample_i > max_q) ? sample_i : max_q;
    min_nx = (sample_i < min_q) ? sample_i : min_q;
    mean_nx = ({1'b0, index_q} < avg_n) ? mean_sum_q + MEAN_SUM_BITS'(sample_i) : mean_sum_q;
    square = MSQ_BITS'(sample_i) * MSQ_BITS'(sample_i);
    sq_nx  = square_sum_q + SQUARE_SUM_BITS'(square);

    div_shift = {rem_q, quo_q[SQUARE_SUM_BITS-1]};
    div_ge    = (div_shift >= {1'b0, den_q});
    rem_nx    = div_ge ? EFF_BITS'(div_shift - {1'b0, den_q}) : div_shift[EFF_BITS-1:0];
    quo_nx    = {quo_q[SQUARE_SUM_BITS-2:0], div_ge};

    sq_shift = {srem_q, rad_q[MSQ_BITS-1 -: 2]};
    sq_trial = {1'b0, root_q, 2'b01};
    sq_ge    = (sq_shift >= sq_trial);
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q  <= WINDOW_RESET;
      mean_cfg_q <= MEAN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW_COUNT: win_cfg_q  <= cfg_data_i;
        REG_MEAN_COUNT:   mean_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // window accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q      <= '0;
      max_q        <= '0;
      min_q        <= '1;
      mean_sum_q   <= '0;
      square_sum_q <= '0;
    end else if (cmd_i.accept) begin
      if (cmd_i.close) begin
        index_q      <= '0;
        max_q        <= '0;
        min_q        <= '1;
        mean_sum_q   <= '0;
        square_sum_q <= '0;
      end else begin
        index_q      <= taken[COUNT_BITS-1:0];
        max_q        <= max_nx;
        min_q        <= min_nx;
        mean_sum_q   <= mean_nx;
        square_sum_q <= sq_nx;
      end
    end
  end

  // end-of-window arithmetic
  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      snap_max_q   <= max_nx;
      snap_min_q   <= min_nx;
      snap_sq_q    <= sq_nx;
      snap_taken_q <= taken;
      quo_q        <= SQUARE_SUM_BITS'(mean_nx);
      rem_q        <= '0;
      den_q        <= avg_fin;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end else if (cmd_i.mean_fix) begin
      mean_q <= (quo_q > SQUARE_SUM_BITS'({SAMPLE_BITS{1'b1}})) ? '1 : quo_q[SAMPLE_BITS-1:0];
      quo_q  <= snap_sq_q;
      rem_q  <= '0;
      den_q  <= snap_taken_q;
    end

    if (cmd_i.sqrt_set) begin
      rad_q  <= quo_q[MSQ_BITS-1:0];
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[MSQ_BITS-3:0], 2'b00};
      root_q <= {root_q[SAMPLE_BITS-2:0], sq_ge};
      srem_q <= sq_ge ? (SAMPLE_BITS+1)'(sq_shift - sq_trial) : sq_shift[SAMPLE_BITS:0];
    end

    if (cmd_i.publish) begin
      out_max_q  <= snap_max_q;
      out_min_q  <= snap_min_q;
      out_p2p_q  <= snap_max_q - snap_min_q;
      out_mean_q <= mean_q;
      out_rms_q  <= root_q;
    end
  end

  assign max_value_o    = out_max_q;
  assign min_value_o    = out_min_q;
  assign peak_to_peak_o = out_p2p_q;
  assign mean_value_o   = out_mean_q;
  assign rms_value_o    = out_rms_q;

endmodule

### rtl/wss_ctrl.sv
// ----------------------------------------------------------------------------
// wss_ctrl
// Sequencer for the windowed statistics block: sample acceptance, the two
// divisions, the square root and the output register handshake.
// ----------------------------------------------------------------------------
module wss_ctrl
  import wss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  input  wss_status_t status_i,
  output wss_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_MEAN = 3'd1;
  localparam logic [2:0] ST_MEAN_FIX = 3'd2;
  localparam logic [2:0] ST_DIV_MSQ  = 3'd3;
  localparam logic [2:0] ST_SQRT_SET = 3'd4;
  localparam logic [2:0] ST_SQRT     = 3'd5;
  localparam logic [2:0] ST_PUBLISH  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [STEP_BITS-1:0] cnt_q, cnt_d;
  logic                 out_full_q, out_full_d;
  logic                 out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_full_q;
  assign out_free    = !out_full_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        cmd_o.close  = in_valid_i && status_i.close;
        if (cmd_o.close) begin
          state_d = ST_DIV_MEAN;
          cnt_d   = '0;
        end
      end
      ST_DIV_MEAN, ST_DIV_MSQ: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + STEP_BITS'(1);
        if (cnt_q == STEP_BITS'(DIV_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == ST_DIV_MEAN) ? ST_MEAN_FIX : ST_SQRT_SET;
        end
      end
      ST_MEAN_FIX: begin
        cmd_o.mean_fix = 1'b1;
        state_d = ST_DIV_MSQ;
      end
      ST_SQRT_SET: begin
        cmd_o.sqrt_set = 1'b1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + STEP_BITS'(1);
        if (cnt_q == STEP_BITS'(SQRT_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.publish) begin
      out_full_d = 1'b1;
    end else if (!out_stall_i) begin
      out_full_d = 1'b0;
    end else begin
      out_full_d = out_full_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      out_full_q <= out_full_d;
    end
  end

endmodule

### rtl/windowed_sample_statistics_core.sv
// ----------------------------------------------------------------------------
// windowed_sample_statistics_core
// Max, min, peak-to-peak, mean and rms over a window of converter samples.
//
// Samples enter on in_valid_i / in_stall_o, one transaction per sample; results
// leave on out_valid_o / out_stall_i, one transaction per completed window.
// cfg_we_i writes window_count (index 0) or mean_count (index 1); the user is
// to write them only while idle, and the block itself does not enforce this;
// a count of zero stands for 65536. A sample that does not close the window
// is taken at once, so the input runs at one sample per clock while in_stall_o
// is low. The sample that closes the window starts the end-of-window
// arithmetic: a 40-step restoring division for the mean, a 40-step division
// for the mean square and a 12-step square root, all in one shared sequencer;
// in_stall_o then stays high until out_valid_o shows the result.
// The result sits in an output register; if the receiver stalls, it holds and
// the next window is taken in meanwhile, but a further result waits for the
// register to empty before the input opens again.
// Reset restores the default counts, empties the window and the output.
// ----------------------------------------------------------------------------
module windowed_sample_statistics_core
  import wss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COUNT_BITS-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SAMPLE_BITS-1:0]  max_value_o,
  output logic [SAMPLE_BITS-1:0]  min_value_o,
  output logic [SAMPLE_BITS-1:0]  peak_to_peak_o,
  output logic [SAMPLE_BITS-1:0]  mean_value_o,
  output logic [SAMPLE_BITS-1:0]  rms_value_o
);

  wss_cmd_t    cmd;
  wss_status_t status;

  wss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wss_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (sample_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .max_value_o    (max_value_o),
    .min_value_o    (min_value_o),
    .peak_to_peak_o (peak_to_peak_o),
    .mean_value_o   (mean_value_o),
    .rms_value_o    (rms_value_o)
  );

endmodule

### tb/window_stats_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_stats_checker
// Watches the sample and result channels and the register write port of the
// windowed statistics core. It keeps its own copy of the window accumulators
// and the two counts, and works out max, min, peak-to-peak, mean and rms for
// every window that an accepted sample closes. Each accepted result is
// compared field by field with the oldest window still awaited.
// ----------------------------------------------------------------------------
module window_stats_checker
  import wss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COUNT_BITS-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [SAMPLE_BITS-1:0]  max_value_i,
  input  logic [SAMPLE_BITS-1:0]  min_value_i,
  input  logic [SAMPLE_BITS-1:0]  peak_to_peak_i,
  input  logic [SAMPLE_BITS-1:0]  mean_value_i,
  input  logic [SAMPLE_BITS-1:0]  rms_value_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  // index 0 max, 1 min, 2 peak-to-peak, 3 mean, 4 rms
  typedef logic [4:0][SAMPLE_BITS-1:0] window_stats_t;

  localparam string FIELD_NAME [5] = '{"max_value", "min_value", "peak_to_peak",
                                       "mean_value", "rms_value"};

  logic [COUNT_BITS-1:0]      window_reg;
  logic [COUNT_BITS-1:0]      mean_reg;
  logic [COUNT_BITS-1:0]      taken_count;
  logic [SAMPLE_BITS-1:0]     peak_hi;
  logic [SAMPLE_BITS-1:0]     peak_lo;
  logic [MEAN_SUM_BITS-1:0]   level_sum;
  logic [SQUARE_SUM_BITS-1:0] energy_sum;
  window_stats_t              awaited_windows [$];
  window_stats_t              want;
  window_stats_t              seen;
  int                         errors;

  function automatic int unsigned span(input logic [COUNT_BITS-1:0] count);
    return (count == '0) ? 65536 : int'(count);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] floor_sqrt(input logic [SQUARE_SUM_BITS-1:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = SQUARE_SUM_BITS / 2; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= 64'(v)) root = trial;
    end
    return root[SAMPLE_BITS-1:0];
  endfunction

  function automatic void clear_window();
    taken_count = '0;
    peak_hi     = '0;
    peak_lo     = '1;
    level_sum   = '0;
    energy_sum  = '0;
  endfunction

  function automatic void absorb_sample(input logic [SAMPLE_BITS-1:0] s);
    int unsigned                win;
    int unsigned                avg;
    int unsigned                taken;
    logic [MEAN_SUM_BITS-1:0]   mean;
    logic [SQUARE_SUM_BITS-1:0] mean_sq;
    window_stats_t              stats;
    win = span(window_reg);
    avg = span(mean_reg);
    if (avg > win) avg = win;
    if (s > peak_hi) peak_hi = s;
    if (s < peak_lo) peak_lo = s;
    if (taken_count < avg) level_sum = level_sum + s;
    energy_sum = energy_sum + SQUARE_SUM_BITS'(s) * SQUARE_SUM_BITS'(s);
    taken = taken_count + 1;
    if (taken < win) begin
      taken_count = taken[COUNT_BITS-1:0];
    end else begin
      if (avg > taken) avg = taken;
      mean    = level_sum / avg;
      mean_sq = energy_sum / taken;
      stats[0] = peak_hi;
      stats[1] = peak_lo;
      stats[2] = peak_hi - peak_lo;
      stats[3] = (mean > MEAN_SUM_BITS'({SAMPLE_BITS{1'b1}})) ? {SAMPLE_BITS{1'b1}}
                                                               : mean[SAMPLE_BITS-1:0];
      stats[4] = floor_sqrt(mean_sq);
      awaited_windows.push_back(stats);
      clear_window();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_reg = WINDOW_RESET;
      mean_reg   = MEAN_RESET;
      clear_window();
      awaited_windows.delete();
      errors = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_WINDOW_COUNT) window_reg = cfg_data_i;
        else if (cfg_index_i == REG_MEAN_COUNT) mean_reg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) absorb_sample(sample_i);
      if (out_valid_i && !out_stall_i) begin
        seen = {rms_value_i, mean_value_i, peak_to_peak_i, min_value_i, max_value_i};
        if (awaited_windows.size() == 0) begin
          $display("%0t: result transaction with nothing awaited: expected none, actual %h",
                   $time, seen);
          errors++;
        end else begin
          want = awaited_windows.pop_front();
          for (int f = 0; f < 5; f++) begin
            if (want[f] !== seen[f]) begin
              $display("%0t: %s mismatch: expected %0d, actual %0d",
                       $time, FIELD_NAME[f], want[f], seen[f]);
              errors++;
            end
          end
        end
      end
      fail_count_o <= errors;
      pending_o    <= awaited_windows.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the windowed sample statistics core. A directed
// part covers the sample extremes, zero and oversized counts and counts
// changed part-way through a window; then a long back-pressure stretch, a
// zero window count that is shrunk part-way, and many random phases with
// small windows, random gaps on both sides and register changes between
// phases.
// ----------------------------------------------------------------------------
module testbench;
  import wss_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COUNT_BITS-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic [SAMPLE_BITS-1:0]  sample = '0;
  logic                    out_stall = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic [SAMPLE_BITS-1:0]  max_value;
  logic [SAMPLE_BITS-1:0]  min_value;
  logic [SAMPLE_BITS-1:0]  peak_to_peak;
  logic [SAMPLE_BITS-1:0]  mean_value;
  logic [SAMPLE_BITS-1:0]  rms_value;
  int                      err_count;
  int                      outstanding;

  bit tx_quiet    = 1'b0;
  bit tx_sparse   = 1'b0;
  bit rx_quiet    = 1'b0;
  bit rx_hold_req = 1'b0;

  windowed_sample_statistics_core u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .max_value_o    (max_value),
    .min_value_o    (min_value),
    .peak_to_peak_o (peak_to_peak),
    .mean_value_o   (mean_value),
    .rms_value_o    (rms_value)
  );

  window_stats_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .sample_i       (sample),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .max_value_i    (max_value),
    .min_value_i    (min_value),
    .peak_to_peak_i (peak_to_peak),
    .mean_value_i   (mean_value),
    .rms_value_i    (rms_value),
    .fail_count_o   (err_count),
    .pending_o      (outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_BITS'($urandom_range(0, 15));
      3:       return SAMPLE_BITS'(4095 - $urandom_range(0, 15));
      default: return SAMPLE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    if (tx_quiet) gap = 0;
    else if (tx_sparse) gap = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 6) : 0;
    else gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // input closed, then wait for every awaited window and for the arithmetic to drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic load_counts(input logic [COUNT_BITS-1:0] win,
                             input logic [COUNT_BITS-1:0] mean);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_COUNT;
    cfg_data  <= win;
    @(posedge clk);
    cfg_index <= REG_MEAN_COUNT;
    cfg_data  <= mean;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: stall a drawn number of cycles once a result shows
  initial begin : rx_side
    int gap;
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 6);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        rx_hold_req = 1'b0;
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        repeat (gap - 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int                    sent;
    int                    n;
    logic [COUNT_BITS-1:0] win;
    logic [COUNT_BITS-1:0] mean;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-sample windows at the sample extremes
    load_counts(16'd1, 16'd1);
    send_sample('0);
    send_sample('1);
    send_sample(12'h800);
    send_sample(12'h7FF);
    settle();
    // zero mean count, limited to the window
    load_counts(16'd4, 16'd0);
    send_sample('1);
    send_sample('0);
    send_sample('1);
    send_sample('0);
    settle();
    load_counts(16'd3, 16'd5);
    send_sample(12'd1);
    send_sample(12'd2);
    send_sample(12'd4094);
    settle();
    // window shrunk part-way, mean count lowered so the mean saturates
    load_counts(16'd10, 16'd10);
    repeat (6) send_sample('1);
    settle();
    load_counts(16'd3, 16'd2);
    send_sample('1);
    settle();
    // mean count raised part-way
    load_counts(16'd8, 16'd2);
    repeat (3) send_sample(pick_sample());
    settle();
    load_counts(16'd8, 16'd6);
    repeat (5) send_sample(pick_sample());
    settle();

    // long receiver hold-off while samples keep coming
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    load_counts(16'd2, 16'd1);
    rx_hold_req = 1'b1;
    repeat (60) send_sample(pick_sample());
    settle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // zero window count stays open, then the window is shrunk part-way
    tx_sparse = 1'b1;
    load_counts(16'd0, 16'hFFFF);
    repeat (20) send_sample(pick_sample());
    settle();
    load_counts(16'd5, 16'd0);
    send_sample(pick_sample());
    settle();
    tx_sparse = 1'b0;

    sent = 0;
    while (sent < 1440) begin
      win = ($urandom_range(0, 7) == 0) ? COUNT_BITS'($urandom_range(13, 40))
                                        : COUNT_BITS'($urandom_range(1, 12));
      case ($urandom_range(0, 5))
        0:       mean = '0;
        1:       mean = '1;
        2:       mean = 16'd1;
        default: mean = COUNT_BITS'($urandom_range(1, win + 2));
      endcase
      n = $urandom_range(1, 5) * win;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(0, win - 1);
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      load_counts(win, mean);
      repeat (n) send_sample(pick_sample());
      sent += n;
      settle();
    end

    if (err_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/wss_pkg.sv
rtl/wss_datapath.sv
rtl/wss_ctrl.sv
rtl/windowed_sample_statistics_core.sv
tb/window_stats_checker.sv
tb/testbench.sv
